// ----- src/bltu_pkg.sv -----
`timescale 1ns / 1ps
// bltu_pkg: types, constants and decode functions for the byte-level token unescape block
// no dependencies; used by bltu_front, bltu_queue, bltu_back and the top level
package bltu_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;

	localparam logic [20:0] CP_PRINT_LO  = 21'd33;
	localparam logic [20:0] CP_PRINT_HI  = 21'd126;
	localparam logic [20:0] CP_LATIN_LO  = 21'd161;
	localparam logic [20:0] CP_LATIN_MID = 21'd172;
	localparam logic [20:0] CP_LATIN_RES = 21'd174;
	localparam logic [20:0] CP_LATIN_HI  = 21'd255;
	localparam logic [20:0] CP_SHIFT_LO  = 21'd256;
	localparam logic [20:0] CP_SHIFT_HI  = 21'd323;
	localparam logic [6:0]  SHIFT_CTRL_HI = 7'd32;
	localparam logic [6:0]  SHIFT_HIGH_HI = 7'd66;
	localparam logic [7:0]  SHIFT_HIGH_OFS = 8'd94;
	localparam logic [7:0]  SHIFT_SOFT_HYPHEN = 8'd173;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} result_t;

	// one closed group: up to four held bytes, how many, and end-of-string mark
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      n;
		logic            last;
	} group_t;

	typedef struct packed {
		logic [3:0][7:0] raw;
		logic [2:0]      count;
	} decode_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] value;
	} map_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		priority if ((b & LEAD2_MASK) == LEAD2_CODE) return 3'd2;
		else if ((b & LEAD3_MASK) == LEAD3_CODE) return 3'd3;
		else if ((b & LEAD4_MASK) == LEAD4_CODE) return 3'd4;
		else return 3'd1;
	endfunction

	function automatic map_t map_code_point(input logic [20:0] cp);
		map_t       m;
		logic [6:0] ofs;
		m.hit = 1'b0;
		m.value = cp[7:0];
		ofs = 7'(cp - CP_SHIFT_LO);
		if ((cp >= CP_PRINT_LO && cp <= CP_PRINT_HI) ||
			(cp >= CP_LATIN_LO && cp <= CP_LATIN_MID) ||
			(cp >= CP_LATIN_RES && cp <= CP_LATIN_HI)) begin
			m.hit = 1'b1;
		end else if (cp >= CP_SHIFT_LO && cp <= CP_SHIFT_HI) begin
			m.hit = 1'b1;
			priority if (ofs <= SHIFT_CTRL_HI) m.value = 8'(ofs);
			else if (ofs <= SHIFT_HIGH_HI) m.value = 8'(ofs) + SHIFT_HIGH_OFS;
			else m.value = SHIFT_SOFT_HYPHEN;
		end
		return m;
	endfunction

	// parse up to four bytes as a complete string
	function automatic decode_t decode_group(input logic [3:0][7:0] src, input logic [2:0] n);
		decode_t    r;
		logic [2:0] i;
		logic [2:0] len;
		logic [20:0] cp;
		map_t       m;
		logic [7:0] b0, b1, b2, b3;
		r = '0;
		i = '0;
		for (int s = 0; s < 4; s++) begin
			if (i < n) begin
				b0 = src[i[1:0]];
				b1 = src[2'(i + 3'd1)];
				b2 = src[2'(i + 3'd2)];
				b3 = src[2'(i + 3'd3)];
				len = lead_length(b0);
				if (len > 3'd1 && ({1'b0, i} + {1'b0, len}) <= {1'b0, n}) begin
					unique case (len)
						3'd2: cp = {10'd0, b0[4:0], b1[5:0]};
						3'd3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
						default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
					endcase
					m = map_code_point(cp);
					if (m.hit) begin
						r.raw[r.count[1:0]] = m.value;
						r.count = r.count + 3'd1;
					end else begin
						for (int k = 0; k < 4; k++) begin
							if (3'(k) < len) begin
								r.raw[r.count[1:0]] = src[2'(i + 3'(k))];
								r.count = r.count + 3'd1;
							end
						end
					end
					i = i + len;
				end else begin
					r.raw[r.count[1:0]] = b0;
					r.count = r.count + 3'd1;
					i = i + 3'd1;
				end
			end
		end
		return r;
	endfunction

endpackage

// ----- src/bltu_front.sv -----
`timescale 1ns / 1ps
// bltu_front: takes input bytes, collects multi-byte groups, closes them into group records
// depends on bltu_pkg
module bltu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  bltu_pkg::item_t  item,
	output logic             grp_valid,
	input  logic             grp_ready,
	output bltu_pkg::group_t grp
);
	import bltu_pkg::*;

	logic [2:0][7:0] pend_q;
	logic [1:0]      count_q;
	logic [2:0]      glen_q;

	logic            accept;
	logic [2:0]      need;
	logic [2:0]      n;
	logic            close;
	logic [3:0][7:0] held;

	assign item_ready = grp_ready;
	assign accept     = item_valid && item_ready;
	assign need       = (count_q == 2'd0) ? lead_length(item.text_byte) : glen_q;
	assign n          = {1'b0, count_q} + 3'd1;
	assign close      = (n >= need) || item.end_of_text;

	always_comb begin
		held = {8'd0, pend_q};
		held[count_q] = item.text_byte;
	end

	assign grp_valid = accept && close;
	assign grp.bytes = held;
	assign grp.n     = n;
	assign grp.last  = item.end_of_text;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			glen_q  <= '0;
		end else if (accept) begin
			if (close) begin
				count_q <= '0;
				glen_q  <= '0;
			end else begin
				count_q <= n[1:0];
				glen_q  <= need;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !close) begin
			pend_q[count_q] <= item.text_byte;
		end
	end

endmodule

// ----- src/bltu_queue.sv -----
`timescale 1ns / 1ps
// bltu_queue: short first-in first-out queue of group records between front and back
// depends on bltu_pkg
module bltu_queue #(
	parameter int unsigned DEPTH = bltu_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  bltu_pkg::group_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output bltu_pkg::group_t pop_data
);
	import bltu_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	group_t          store [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [CW-1:0]   fill_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (fill_q != CW'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = store[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + CW'(1);
				2'b01:   fill_q <= fill_q - CW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store[wr_q] <= push_data;
		end
	end

endmodule

// ----- src/bltu_back.sv -----
`timescale 1ns / 1ps
// bltu_back: decodes the head group record and sends its raw bytes one per cycle while result_ready is high
// depends on bltu_pkg
module bltu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               grp_valid,
	output logic               grp_ready,
	input  bltu_pkg::group_t   grp,
	output logic               result_valid,
	input  logic               result_ready,
	output bltu_pkg::result_t  result
);
	import bltu_pkg::*;

	logic [3:0][7:0] raw_q;
	logic [2:0]      cnt_q;
	logic            last_q;
	logic [1:0]      idx_q;
	logic            valid_q;

	decode_t         dec;
	logic            final_beat;
	logic            send;
	logic            load;

	assign dec        = decode_group(grp.bytes, grp.n);
	assign final_beat = (idx_q == 2'(cnt_q - 3'd1));
	assign send       = valid_q && result_ready;
	assign grp_ready  = !valid_q || (send && final_beat);
	assign load       = grp_valid && grp_ready;

	assign result_valid    = valid_q;
	assign result.out_byte = raw_q[idx_q];
	assign result.out_last = last_q && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (send) begin
			if (final_beat) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			raw_q  <= dec.raw;
			cnt_q  <= dec.count;
			last_q <= grp.last;
		end
	end

endmodule

// ----- src/byte_level_token_unescape_core.sv -----
`timescale 1ns / 1ps
// byte_level_token_unescape_core: up to one escaped byte in and one raw byte out per cycle
// the group a closing request completes is queued, then registered in the back stage
// throughput: 1 request in and 1 back-stage result byte out per cycle, unless stalled
// each group holds the back stage until its decoded bytes are out; results never outnumber inputs
// reset: asynchronous, active low; clears group collection, queue pointers and output valid
module byte_level_token_unescape_core #(
	parameter int unsigned QDEPTH = bltu_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  bltu_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_ready,
	output bltu_pkg::result_t  result
);
	import bltu_pkg::*;

	// front to queue
	logic   fq_valid;
	logic   fq_ready;
	group_t fq_grp;

	// queue to back
	logic   qb_valid;
	logic   qb_ready;
	group_t qb_grp;

	// front: holds lead and continuation bytes until the group is complete or
	// the string ends, then hands the whole group over as one record
	bltu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.grp_valid  (fq_valid),
		.grp_ready  (fq_ready),
		.grp        (fq_grp)
	);

	// decoupling queue so input can keep flowing while the back stage
	// is still sending the bytes of a pass-through group
	bltu_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_grp),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_grp)
	);

	// back: decodes the group (mapped code point or pass-through, with the
	// short-tail reparse), registers the raw bytes and streams them out
	bltu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.grp_valid    (qb_valid),
		.grp_ready    (qb_ready),
		.grp          (qb_grp),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ----- bench/tb_byte_level_token_unescape_core.sv -----
`timescale 1ns / 1ps
// tb_byte_level_token_unescape_core: self-checking bench for the byte-level token unescape core
// needs bltu_pkg and byte_level_token_unescape_core; directed table first, then random strings
module tb_byte_level_token_unescape_core;
	import bltu_pkg::*;

	localparam int DIR_ROWS     = 24;
	localparam int RANDOM_ITEMS = 406;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 20;

	// one directed request; typed rows carry their expected bytes, others use the predictor
	typedef struct packed {
		logic [7:0]      text;
		logic            eot;
		logic            typed;
		logic [2:0]      n;
		logic [3:0][7:0] wanted;
	} dir_row_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_ready;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// predictor copy of the group collector
	logic [7:0] held_bytes [3];
	logic [1:0] held_count;
	logic [2:0] group_len;

	result_t     step_out [$];   // bytes produced by the latest request
	result_t     raw_due [$];    // decoded bytes still owed by the block
	logic [7:0]  token_bytes [$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	bit          calm = 1'b0;    // no idling on either side while set

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{8'h41, 1'b1, 1'b1, 3'd1, 32'h41},   // printable byte, whole string
		'{8'h00, 1'b0, 1'b1, 3'd1, 32'h00},   // lowest byte passes through
		'{8'hFF, 1'b1, 1'b1, 3'd1, 32'hFF},   // highest byte is no lead
		'{8'hC4, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'hA0, 1'b1, 1'b1, 3'd1, 32'h20},   // shifted control range gives space
		'{8'hC0, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'h81, 1'b0, 1'b0, 3'd0, 32'h00},   // overlong, code point 1 not in map
		'{8'hC5, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'h83, 1'b0, 1'b0, 3'd0, 32'h00},   // top of shifted range, soft hyphen
		'{8'hC4, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'hA1, 1'b0, 1'b0, 3'd0, 32'h00},   // first of the high block, gives 7f
		'{8'hE1, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'h80, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'h80, 1'b0, 1'b0, 3'd0, 32'h00},   // three-byte group out of map
		'{8'hF0, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'h80, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'h84, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'h80, 1'b0, 1'b0, 3'd0, 32'h00},   // four-byte group, bottom of shifted range
		'{8'hC4, 1'b1, 1'b1, 3'd1, 32'hC4},   // string ends on a lone lead byte
		'{8'hF0, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'hC4, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'hA0, 1'b1, 1'b0, 3'd0, 32'h00},   // early end, tail holds a group that fits
		'{8'hE2, 1'b0, 1'b1, 3'd0, 32'h00},
		'{8'h41, 1'b1, 1'b0, 3'd0, 32'h00}    // early end, nothing fits
	};

	byte_level_token_unescape_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #10 clk = ~clk;

	// group length that a byte opens when it starts a group
	function automatic logic [2:0] group_size(input logic [7:0] b);
		casez (b)
			8'b110?????: return 3'd2;
			8'b1110????: return 3'd3;
			8'b11110???: return 3'd4;
			default: return 3'd1;
		endcase
	endfunction

	// advance the collector by one request and fill step_out with the bytes it yields
	function automatic void predict_unescape(input item_t req);
		logic [7:0]  tail [4];
		logic [7:0]  raw_out [$];
		logic [7:0]  mapped;
		logic [20:0] cp;
		int unsigned n;
		int unsigned need;
		int unsigned pos;
		int unsigned len;
		bit          hit;
		result_t     r;
		step_out.delete();
		for (int k = 0; k < 4; k++) tail[k] = (k < held_count) ? held_bytes[k] : 8'h00;
		tail[held_count] = req.text_byte;
		n = held_count + 1;
		need = (held_count == 0) ? group_size(req.text_byte) : group_len;
		// still collecting a group, nothing comes out yet
		if (n < need && !req.end_of_text) begin
			held_bytes[held_count] = req.text_byte;
			held_count = 2'(n);
			group_len = 3'(need);
			return;
		end
		held_count = 2'd0;
		group_len = 3'd0;
		// parse the held bytes as a complete string; a group that does not fit passes through
		pos = 0;
		while (pos < n) begin
			len = group_size(tail[pos]);
			if (len > 1 && pos + len <= n) begin
				case (len)
					2: cp = {10'd0, tail[pos][4:0], tail[pos + 1][5:0]};
					3: cp = {5'd0, tail[pos][3:0], tail[pos + 1][5:0], tail[pos + 2][5:0]};
					default: cp = {tail[pos][2:0], tail[pos + 1][5:0], tail[pos + 2][5:0],
						tail[pos + 3][5:0]};
				endcase
				hit = 1'b1;
				mapped = cp[7:0];
				if ((cp >= 33 && cp <= 126) || (cp >= 161 && cp <= 172) ||
					(cp >= 174 && cp <= 255)) begin
					mapped = cp[7:0];
				end else if (cp >= 256 && cp <= 288) begin
					mapped = 8'(cp - 256);          // control bytes and space
				end else if (cp >= 289 && cp <= 322) begin
					mapped = 8'(cp - 256 + 94);     // 127 up to 160
				end else if (cp == 323) begin
					mapped = 8'd173;                // soft hyphen
				end else begin
					hit = 1'b0;
				end
				if (hit) begin
					raw_out = {raw_out, mapped};
				end else begin
					for (int k = 0; k < len; k++) raw_out = {raw_out, tail[pos + k]};
				end
				pos = pos + len;
			end else begin
				raw_out = {raw_out, tail[pos]};
				pos = pos + 1;
			end
		end
		foreach (raw_out[k]) begin
			r.out_byte = raw_out[k];
			r.out_last = req.end_of_text && (k == raw_out.size() - 1);
			step_out = {step_out, r};
		end
	endfunction

	// offer one request, idling at random first, and predict once it is taken
	task automatic send_byte(input logic [7:0] b, input logic eot, input bit from_model);
		item_t req;
		req.text_byte = b;
		req.end_of_text = eot;
		while (!calm && $urandom_range(0, 99) < 32) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (!item_ready);
		predict_unescape(req);
		if (from_model) foreach (step_out[k]) raw_due = {raw_due, step_out[k]};
	endtask

	// hold requests off until every owed byte has come out
	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (raw_due.size() != 0);
	endtask

	// output side: random stalls, every taken byte checked against the oldest owed one
	always @(posedge clk) begin : drain
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (raw_due.size() == 0) begin
					$display("%0t: unexpected byte, expected none, got out_byte %02h out_last %0b",
						$time, result.out_byte, result.out_last);
					mismatch_count++;
				end else begin
					want = raw_due.pop_front();
					if (result.out_byte !== want.out_byte) begin
						$display("%0t: out_byte expected %02h, got %02h",
							$time, want.out_byte, result.out_byte);
						mismatch_count++;
					end
					if (result.out_last !== want.out_last) begin
						$display("%0t: out_last expected %0b, got %0b",
							$time, want.out_last, result.out_last);
						mismatch_count++;
					end
				end
			end
			result_ready <= calm || ($urandom_range(0, 99) >= 32);
		end
	end

	// cycles without any handshake on either side
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		result_t     r;
		int unsigned random_sent;
		int unsigned parts;
		int unsigned kind;
		int unsigned cp;
		int unsigned cut;
		bit          drained_mid;
		random_sent = 0;
		drained_mid = 1'b0;
		held_count = 2'd0;
		group_len = 3'd0;
		for (int k = 0; k < 3; k++) held_bytes[k] = 8'h00;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++) begin
			send_byte(dir_rows[i].text, dir_rows[i].eot, !dir_rows[i].typed);
			if (dir_rows[i].typed) begin
				for (int k = 0; k < dir_rows[i].n; k++) begin
					r.out_byte = dir_rows[i].wanted[k];
					r.out_last = dir_rows[i].eot && (k == dir_rows[i].n - 1);
					raw_due = {raw_due, r};
				end
			end
		end
		wait_drained();

		// random strings, mostly well-formed groups with some noise and early ends
		while (random_sent < RANDOM_ITEMS) begin
			// once midway the sender stops until the output side has caught up
			if (!drained_mid && random_sent >= RANDOM_ITEMS / 2) begin
				drained_mid = 1'b1;
				wait_drained();
			end
			calm <= (random_sent >= 100 && random_sent < 200);
			token_bytes.delete();
			parts = $urandom_range(1, 4);
			repeat (parts) begin
				kind = $urandom_range(0, 99);
				if (kind < 55) begin
					// proper encoding of a code point around the escape map
					cp = $urandom_range(0, 340);
					if (cp < 128) begin
						token_bytes = {token_bytes, 8'(cp)};
					end else begin
						token_bytes = {token_bytes, 8'hC0 | 8'(cp >> 6)};
						token_bytes = {token_bytes, 8'h80 | 8'(cp & 63)};
					end
				end else if (kind < 70) begin
					// two-byte group, continuation top bits unchecked
					token_bytes = {token_bytes, 8'hC0 | 8'($urandom_range(0, 31))};
					token_bytes = {token_bytes, 8'($urandom_range(0, 255))};
				end else if (kind < 82) begin
					token_bytes = {token_bytes, 8'hE0 | 8'($urandom_range(0, 15))};
					token_bytes = {token_bytes, 8'($urandom_range(0, 255))};
					token_bytes = {token_bytes, 8'($urandom_range(0, 255))};
				end else if (kind < 92) begin
					token_bytes = {token_bytes, 8'hF0 | 8'($urandom_range(0, 7))};
					if ($urandom_range(0, 1)) begin
						// overlong form landing near the shifted range
						token_bytes = {token_bytes, 8'h80};
						token_bytes = {token_bytes, 8'h80 | 8'($urandom_range(2, 5))};
					end else begin
						token_bytes = {token_bytes, 8'($urandom_range(0, 255))};
						token_bytes = {token_bytes, 8'($urandom_range(0, 255))};
					end
					token_bytes = {token_bytes, 8'($urandom_range(0, 255))};
				end else begin
					token_bytes = {token_bytes, 8'($urandom_range(0, 255))};
				end
			end
			// cut the string short so a group is left open at the end
			if ($urandom_range(0, 99) < 20 && token_bytes.size() > 1) begin
				cut = $urandom_range(1, (token_bytes.size() > 2) ? 2 : 1);
				repeat (cut) void'(token_bytes.pop_back());
			end
			foreach (token_bytes[k]) send_byte(token_bytes[k], k == token_bytes.size() - 1, 1'b1);
			random_sent += token_bytes.size();
		end

		calm <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
